[design/gf256_pkg.sv]
// Shared types, codes and table builders for the GF(2^8) arithmetic unit.
`default_nettype none

package gf256_pkg;

  localparam int unsigned FieldBits = 8;
  localparam int unsigned TblDepth  = 1 << FieldBits;
  // Multiplicative group order, 2^8 - 1
  localparam logic [FieldBits:0] GfOrder = 9'd255;
  // x^8 + x^4 + x^3 + x^2 + 1, octal 0435
  localparam logic [FieldBits:0] GfPoly = 9'o435;
  localparam logic [FieldBits-1:0] DivZeroVal = 8'hff;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_MUL = 2'd1,
    ACT_DIV = 2'd2,
    ACT_MAC = 2'd3
  } action_e;

  typedef logic [FieldBits-1:0] rom_t [TblDepth];

  // Per-word control carried alongside the table reads
  typedef struct packed {
    action_e                act;
    logic                   a_zero;
    logic                   b_zero;
    logic [FieldBits-1:0]   sum;
    logic [FieldBits-1:0]   acc;
    logic                   last;
  } stage_ctl_t;

  // Antilog table: entry i holds alpha^i, entry 255 wraps to alpha^0
  function automatic rom_t gf_exp_table();
    rom_t                 tbl;
    logic [FieldBits:0]   x;
    x = 9'd1;
    for (int i = 0; i < TblDepth - 1; i++) begin
      tbl[i] = x[FieldBits-1:0];
      x = x << 1;
      if (x[FieldBits]) begin
        x = x ^ GfPoly;
      end
    end
    tbl[TblDepth-1] = 8'd1;
    return tbl;
  endfunction

  // Log table: entry x holds i with alpha^i == x; entry 0 is unused
  function automatic rom_t gf_log_table();
    rom_t                 tbl;
    logic [FieldBits:0]   x;
    tbl = '{default: '0};
    x = 9'd1;
    for (int i = 0; i < TblDepth - 1; i++) begin
      tbl[x[FieldBits-1:0]] = FieldBits'(i);
      x = x << 1;
      if (x[FieldBits]) begin
        x = x ^ GfPoly;
      end
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

[design/gf256_log_rom.sv]
// Dual-port synchronous log ROM for the two operands.
`default_nettype none

module gf256_log_rom
  import gf256_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [FieldBits-1:0] addr_a_i,
  input  wire logic [FieldBits-1:0] addr_b_i,
  output logic      [FieldBits-1:0] data_a_o,
  output logic      [FieldBits-1:0] data_b_o
);

  localparam rom_t LogRom = gf_log_table();

  logic [FieldBits-1:0] data_a_q;
  logic [FieldBits-1:0] data_b_q;

  // Read both ports, hold while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= LogRom[addr_a_i];
      data_b_q <= LogRom[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

`default_nettype wire

[design/gf256_exp_rom.sv]
// Synchronous antilog ROM.
`default_nettype none

module gf256_exp_rom
  import gf256_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [FieldBits-1:0] addr_i,
  output logic      [FieldBits-1:0] data_o
);

  localparam rom_t ExpRom = gf_exp_table();

  logic [FieldBits-1:0] data_q;

  // Read one entry, hold while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ExpRom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[design/gf256_arith_unit.sv]
// An accepted input word passes through the log ROM read, the antilog ROM read and the
// output register, each taking one pipeline stage, before its result word reaches the output.
// Throughput: one word per cycle while the output word is not held by out_stall_i.
// A stalled output freezes the whole pipeline; input stall follows it.
// Reset clears the stage valid bits only; the ROMs are constant and need no clearing.
`default_nettype none

module gf256_arith_unit
  import gf256_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           action_i,
  input  wire logic [FieldBits-1:0] operand_a_i,
  input  wire logic [FieldBits-1:0] operand_b_i,
  input  wire logic [FieldBits-1:0] accumulator_i,
  input  wire logic                 region_last_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [FieldBits-1:0] result_o,
  output logic                      divide_by_zero_o,
  output logic                      last_o
);

  logic                 advance;
  logic                 v1_q, v1_d, v2_q, v2_d, vo_q, vo_d;
  stage_ctl_t           ctl0, ctl1_q, ctl2_q;
  logic [FieldBits-1:0] log_a, log_b, log_b_eff, exp_idx, exp_val;
  logic [FieldBits:0]   log_sum;
  logic [FieldBits-1:0] prod, res_d, res_q;
  logic                 dz_d, dz_q, last_q;

  // Move all stages together unless the output word is held
  assign advance    = !(vo_q && out_stall_i);
  assign in_stall_o = !advance;

  // Build the control word for the incoming item
  always_comb begin
    ctl0.act    = action_e'(action_i);
    ctl0.a_zero = (operand_a_i == '0);
    ctl0.b_zero = (operand_b_i == '0);
    ctl0.sum    = operand_a_i ^ operand_b_i;
    ctl0.acc    = accumulator_i;
    ctl0.last   = region_last_i;
  end

  gf256_log_rom u_log_rom (
    .clk_i    (clk_i),
    .en_i     (advance),
    .addr_a_i (operand_a_i),
    .addr_b_i (operand_b_i),
    .data_a_o (log_a),
    .data_b_o (log_b)
  );

  // Add logs for multiply, subtract for divide, both modulo 255
  always_comb begin
    log_b_eff = (ctl1_q.act == ACT_DIV) ? FieldBits'(GfOrder) - log_b : log_b;
    log_sum   = {1'b0, log_a} + {1'b0, log_b_eff};
    if (log_sum >= GfOrder) begin
      exp_idx = FieldBits'(log_sum - GfOrder);
    end else begin
      exp_idx = log_sum[FieldBits-1:0];
    end
  end

  gf256_exp_rom u_exp_rom (
    .clk_i  (clk_i),
    .en_i   (advance),
    .addr_i (exp_idx),
    .data_o (exp_val)
  );

  // Select the result for the action
  always_comb begin
    prod  = (ctl2_q.a_zero || ctl2_q.b_zero) ? '0 : exp_val;
    res_d = prod;
    dz_d  = 1'b0;
    case (ctl2_q.act)
      ACT_ADD: res_d = ctl2_q.sum;
      ACT_MUL: res_d = prod;
      ACT_DIV: begin
        if (ctl2_q.b_zero) begin
          res_d = DivZeroVal;
          dz_d  = 1'b1;
        end
      end
      ACT_MAC: res_d = ctl2_q.acc ^ prod;
      default: res_d = prod;
    endcase
  end

  // Advance stage valids
  always_comb begin
    v1_d = advance ? in_valid_i : v1_q;
    v2_d = advance ? v1_q : v2_q;
    vo_d = advance ? v2_q : vo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      vo_q <= vo_d;
    end
  end

  // Carry payload alongside the ROM reads
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl1_q <= ctl0;
      ctl2_q <= ctl1_q;
      res_q  <= res_d;
      dz_q   <= dz_d;
      last_q <= ctl2_q.last;
    end
  end

  assign out_valid_o      = vo_q;
  assign result_o         = res_q;
  assign divide_by_zero_o = dz_q;
  assign last_o           = last_q;

  a_dz_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> result_o == DivZeroVal)
    else $error("divide-by-zero word without saturated result");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v1_q)
    else $error("accepted word lost at stage one");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !advance |=> v2_q && $stable(ctl2_q))
    else $error("stage two changed during stall");

  a_stage_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && advance |=> out_valid_o)
    else $error("stage two word not delivered to output");

endmodule

`default_nettype wire
